// ===== rtl/sine_table_sample_generator_core_defines.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef SINE_TABLE_SAMPLE_GENERATOR_CORE_DEFINES_SVH
`define SINE_TABLE_SAMPLE_GENERATOR_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define STG_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");
// next-cycle implication checked outside reset
`define STG_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");
`endif

// ===== rtl/stg_pkg.sv =====
// package of the sine sample generator: widths, cordic constants, types
// no dependencies
package stg_pkg;
	localparam int IDX_W = 12;
	localparam int SMP_W = 12;
	localparam int AMP_W = 11;
	localparam int PER_W = 13;
	localparam int CFG_W = 13;
	localparam int PH_W = 16;
	localparam int DIV_NUM_W = 28;
	localparam int ANG_W = 34;
	localparam int XY_W = 34;
	localparam int MAX_STEPS = 24;
	localparam logic [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
	localparam logic [SMP_W-1:0] DAC_MAX = 12'd4095;
	localparam logic [AMP_W-1:0] AMP_RESET = 11'd2047;
	localparam logic [PER_W-1:0] PER_RESET = 13'd256;

	typedef enum logic {
		REG_AMPLITUDE = 1'b0,
		REG_PERIOD = 1'b1
	} reg_idx_t;

	// atan(2^-i) in 2^-32 turn units
	function automatic logic [31:0] atan_turn(input int unsigned i);
		logic [31:0] t;
		case (i)
			0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
			3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
			9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
			15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
			21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
			default: t = 32'h0;
		endcase
		return t;
	endfunction
endpackage

// ===== rtl/stg_if.sv =====
// valid/ready channel carrying one 12-bit word
// uses stg_pkg
interface stg_if;
	logic valid;
	logic ready;
	logic [stg_pkg::IDX_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/stg_div.sv =====
// pipelined restoring divider: phase = (index << 16) / period, one quotient bit a stage
// uses stg_pkg
module stg_div (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vin,
	input logic [stg_pkg::IDX_W-1:0] idx,
	input logic [stg_pkg::PER_W-1:0] per,
	input logic [stg_pkg::AMP_W-1:0] amp,
	output logic vout,
	output logic [stg_pkg::PH_W-1:0] phase,
	output logic [stg_pkg::AMP_W-1:0] amp_out
);
	localparam int N = stg_pkg::DIV_NUM_W;
	localparam int RW = stg_pkg::PER_W + 1;

	logic [N-1:0] num_s1 [N+1];
	logic [RW-1:0] rem_s1 [N+1];
	logic [stg_pkg::PER_W-1:0] per_s1 [N+1];
	logic [stg_pkg::AMP_W-1:0] amp_s1 [N+1];
	logic v_s1 [N+1];

	always_comb begin
		num_s1[0] = {idx, 16'd0};
		rem_s1[0] = '0;
		per_s1[0] = per;
		amp_s1[0] = amp;
		v_s1[0] = vin;
	end

	// numerator shifts left as quotient bits enter at the bottom
	for (genvar k = 0; k < N; k++) begin : g_st
		logic [RW:0] trial;
		logic [RW:0] diff;
		assign trial = {rem_s1[k], num_s1[k][N-1]};
		assign diff = trial - {2'd0, per_s1[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[k+1] <= 1'b0;
			end else if (en) begin
				v_s1[k+1] <= v_s1[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[RW]) begin
					rem_s1[k+1] <= diff[RW-1:0];
					num_s1[k+1] <= {num_s1[k][N-2:0], 1'b1};
				end else begin
					rem_s1[k+1] <= trial[RW-1:0];
					num_s1[k+1] <= {num_s1[k][N-2:0], 1'b0};
				end
				per_s1[k+1] <= per_s1[k];
				amp_s1[k+1] <= amp_s1[k];
			end
		end
	end

	// zero period gives phase 0
	assign phase = (per_s1[N] == '0) ? '0 : num_s1[N][stg_pkg::PH_W-1:0];
	assign vout = v_s1[N];
	assign amp_out = amp_s1[N];
endmodule

// ===== rtl/stg_cordic.sv =====
// pipelined rotation cordic and output scaling, one micro-rotation a stage
// uses stg_pkg
module stg_cordic #(
	parameter int STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vin,
	input logic [stg_pkg::PH_W-1:0] phase,
	input logic [stg_pkg::AMP_W-1:0] amp,
	output logic vout,
	output logic [stg_pkg::SMP_W-1:0] sample
);
	localparam int W = stg_pkg::XY_W;
	localparam int AW = stg_pkg::ANG_W;
	localparam int NS = (STEPS > stg_pkg::MAX_STEPS) ? stg_pkg::MAX_STEPS : STEPS;

	logic signed [W-1:0] x_s1 [NS+1];
	logic signed [W-1:0] y_s1 [NS+1];
	logic signed [AW-1:0] z_s1 [NS+1];
	logic neg_s1 [NS+1];
	logic [stg_pkg::AMP_W-1:0] amp_s1 [NS+1];
	logic v_s1 [NS+1];
	logic [31:0] ang;
	logic [31:0] angr;
	logic lefth;

	// left half plane: rotate by half a turn and negate the sine
	always_comb begin
		ang = {phase, 16'd0};
		lefth = ang[31] ^ ang[30];
		angr = lefth ? (ang ^ 32'h80000000) : ang;
		x_s1[0] = stg_pkg::CORDIC_GAIN;
		y_s1[0] = '0;
		z_s1[0] = AW'(signed'(angr));
		neg_s1[0] = lefth;
		amp_s1[0] = amp;
		v_s1[0] = vin;
	end

	for (genvar i = 0; i < NS; i++) begin : g_rot
		localparam logic [31:0] AT = stg_pkg::atan_turn(i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[i+1] <= 1'b0;
			end else if (en) begin
				v_s1[i+1] <= v_s1[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s1[i][AW-1]) begin
					x_s1[i+1] <= x_s1[i] - (y_s1[i] >>> i);
					y_s1[i+1] <= y_s1[i] + (x_s1[i] >>> i);
					z_s1[i+1] <= z_s1[i] - AW'(AT);
				end else begin
					x_s1[i+1] <= x_s1[i] + (y_s1[i] >>> i);
					y_s1[i+1] <= y_s1[i] - (x_s1[i] >>> i);
					z_s1[i+1] <= z_s1[i] + AW'(AT);
				end
				neg_s1[i+1] <= neg_s1[i];
				amp_s1[i+1] <= amp_s1[i];
			end
		end
	end

	// reduce to q1.15, clamp and offset, register with the amplitude, then scale by it
	logic signed [W-1:0] ys;
	logic signed [W-1:0] yn;
	logic [16:0] off;
	logic [16:0] off_q;
	logic [stg_pkg::AMP_W-1:0] amp_q;
	logic v_q;
	logic [27:0] prod;
	logic [12:0] scaled;

	always_comb begin
		ys = y_s1[NS] >>> 15;
		yn = neg_s1[NS] ? -ys : ys;
		if (yn > W'(signed'(32767))) begin
			off = 17'd65535;
		end else if (yn < -W'(signed'(32768))) begin
			off = 17'd0;
		end else begin
			off = 17'(yn + W'(32768));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s1[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_q <= off;
			amp_q <= amp_s1[NS];
		end
	end

	always_comb begin
		prod = 28'(amp_q) * 28'(off_q);
		scaled = prod[27:15];
		sample = scaled[12] ? stg_pkg::DAC_MAX : scaled[11:0];
	end
	assign vout = v_q;
endmodule

// ===== rtl/sine_table_sample_generator_core.sv =====
// top level of the offset sine sample generator
// uses stg_pkg, stg_if, stg_div, stg_cordic
//
//  channel  | dir | word
//  ---------+-----+-------------------------------
//  in_ch    | in  | sample_index, 12 bit
//  out_ch   | out | sample, 12 bit dac code
//  cfg      | in  | cfg_we / cfg_idx / cfg_data
//
// one word enters per cycle while the output is not stalled; the pipe holds 28 divider
// stages, CORDIC_STEPS rotation stages (capped at MAX_STEPS), one scaling stage and the output register
// the whole pipe advances together; a full output register with ready low
// stalls every stage, so nothing is lost or repeated
// arst_n clears valid bits and loads the register reset values
module sine_table_sample_generator_core #(
	parameter int TABLE_DEPTH = 4096,
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	stg_if.sink in_ch,
	stg_if.source out_ch,
	input logic cfg_we,
	input logic cfg_idx,
	input logic [stg_pkg::CFG_W-1:0] cfg_data
);
	localparam int TW = (TABLE_DEPTH > 4096) ? 12 : $clog2(TABLE_DEPTH);

	logic [stg_pkg::AMP_W-1:0] amplitude_q;
	logic [stg_pkg::PER_W-1:0] period_samples_q;
	logic en;
	logic vin;
	logic [stg_pkg::IDX_W-1:0] idx;
	logic dv;
	logic [stg_pkg::PH_W-1:0] phase;
	logic [stg_pkg::AMP_W-1:0] damp;
	logic cv;
	logic [stg_pkg::SMP_W-1:0] csample;
	logic out_v_q;
	logic [stg_pkg::SMP_W-1:0] out_d_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= stg_pkg::AMP_RESET;
			period_samples_q <= stg_pkg::PER_RESET;
		end else if (cfg_we) begin
			case (stg_pkg::reg_idx_t'(cfg_idx))
				stg_pkg::REG_AMPLITUDE: amplitude_q <= cfg_data[stg_pkg::AMP_W-1:0];
				stg_pkg::REG_PERIOD: period_samples_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipe advances unless the output word is held
	assign en = !out_v_q || out_ch.ready;
	assign in_ch.ready = en;
	assign vin = in_ch.valid;
	// index keeps its low clog2(TABLE_DEPTH) bits, at most 12: modulo the depth when it is a power of two
	assign idx = stg_pkg::IDX_W'(in_ch.data[TW-1:0]);

	stg_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(vin), .idx(idx),
		.per(period_samples_q), .amp(amplitude_q),
		.vout(dv), .phase(phase), .amp_out(damp)
	);

	stg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(dv), .phase(phase),
		.amp(damp), .vout(cv), .sample(csample)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= cv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d_q <= csample;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_d_q;
endmodule

// ===== rtl/stg_checker.sv =====
// port-level checker for the sine sample generator, bound to the top level
// uses sine_table_sample_generator_core_defines.svh
`include "sine_table_sample_generator_core_defines.svh"
module stg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [11:0] out_data
);
	// a held output word stays the same
	`STG_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	// input is refused only while a word is stalled at the output
	`STG_ASSERT_IMP(a_ready, clk, arst_n, !in_ready, out_valid && !out_ready)
	// an empty or moving output never blocks the input
	`STG_ASSERT_IMP(a_flow, clk, arst_n, !out_valid || out_ready, in_ready)
endmodule

bind sine_table_sample_generator_core stg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
